// File: rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is active
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// implication checked at every rising edge, off while reset is active
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication failed");

`endif

// File: rtl/prs80_pkg.sv
// package with present-80 constants, s-box and round functions
`timescale 1ns / 1ps

package prs80_pkg;

	localparam int BLOCK_W     = 64;
	localparam int KEY_W       = 80;
	localparam int KEY_LOW_W   = 64;
	localparam int KEY_HIGH_W  = 16;
	localparam int ROUND_COUNT = 31;
	localparam int RC_W        = 5;

	typedef logic [BLOCK_W-1:0] block_t;
	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [RC_W-1:0]    rc_t;

	// 4-bit s-box
	function automatic logic [3:0] sbox(input logic [3:0] x);
		logic [3:0] y;
		case (x)
			4'h0: y = 4'hC;
			4'h1: y = 4'h5;
			4'h2: y = 4'h6;
			4'h3: y = 4'hB;
			4'h4: y = 4'h9;
			4'h5: y = 4'h0;
			4'h6: y = 4'hA;
			4'h7: y = 4'hD;
			4'h8: y = 4'h3;
			4'h9: y = 4'hE;
			4'hA: y = 4'hF;
			4'hB: y = 4'h8;
			4'hC: y = 4'h4;
			4'hD: y = 4'h7;
			4'hE: y = 4'h1;
			4'hF: y = 4'h2;
			default: y = 4'h0;
		endcase
		return y;
	endfunction

	// s-box on all sixteen nibbles
	function automatic block_t sub_nibbles(input block_t x);
		block_t y;
		for (int n = 0; n < BLOCK_W / 4; n++) begin
			y[4*n +: 4] = sbox(x[4*n +: 4]);
		end
		return y;
	endfunction

	// bit i moves to 16*(i mod 4) + i/4
	function automatic block_t permute_bits(input block_t x);
		block_t y;
		for (int i = 0; i < BLOCK_W; i++) begin
			y[16*(i%4) + i/4] = x[i];
		end
		return y;
	endfunction

	// round key is the upper 64 key bits
	function automatic block_t round_key(input key_t k);
		return k[KEY_W-1 -: BLOCK_W];
	endfunction

	// rotate left by 61, s-box on top nibble, round counter into bits 19..15
	function automatic key_t next_key(input key_t k, input rc_t rc);
		key_t n;
		n = {k[18:0], k[KEY_W-1:19]};
		n[KEY_W-1 -: 4] = sbox(n[KEY_W-1 -: 4]);
		n[19:15] = n[19:15] ^ rc;
		return n;
	endfunction

endpackage

// File: rtl/prs80_round.sv
// one registered present-80 round with its key schedule step
`timescale 1ns / 1ps

module prs80_round (
	input  logic              clk,
	input  logic              arst_n,
	input  prs80_pkg::rc_t    rnd,
	input  logic              in_valid,
	input  prs80_pkg::block_t in_state,
	input  prs80_pkg::key_t   in_key,
	output logic              out_valid,
	output prs80_pkg::block_t out_state,
	output prs80_pkg::key_t   out_key
);
	import prs80_pkg::*;

	logic   valid_s1;
	block_t state_s1;
	key_t   key_s1;
	block_t state_d;
	key_t   key_d;

	// add round key, substitute, permute; advance the key
	always_comb begin
		state_d = permute_bits(sub_nibbles(in_state ^ round_key(in_key)));
		key_d   = next_key(in_key, rnd);
	end

	// valid bit of the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		state_s1 <= state_d;
		key_s1   <= key_d;
	end

	assign out_valid = valid_s1;
	assign out_state = state_s1;
	assign out_key   = key_s1;

endmodule

// File: rtl/present80_block_encrypt_core.sv
// top level of the pipelined present-80 encryption core
`timescale 1ns / 1ps
//
// PRESENT-80 block encryption, one round per pipeline stage.
// Request channel: plaintext, key_low and key_high are taken at a rising
// edge with start high and busy low. busy is always low, so a new request
// can be issued in every cycle.
// Result channel: ciphertext is shown for exactly one cycle with done high.
// Path: a request passes through the 31 round stages and then the final key
// addition register, which drives done and ciphertext.
// Throughput: one block per cycle, results leave in request order.
// Reset clears every stage valid bit and the done strobe; blocks in flight
// are dropped. The receiver cannot stall, so the pipeline never stops.
//

`include "assert_macros.svh"

module present80_block_encrypt_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] plaintext,
	input  logic [63:0] key_low,
	input  logic [15:0] key_high,
	output logic        done,
	output logic [63:0] ciphertext
);
	import prs80_pkg::*;

	logic   stage_valid [0:ROUND_COUNT];
	block_t stage_state [0:ROUND_COUNT];
	key_t   stage_key   [0:ROUND_COUNT];
	logic   done_q;
	block_t ciphertext_q;

	// the pipeline never holds off a request
	assign busy = 1'b0;

	// pipeline entry
	assign stage_valid[0] = start & ~busy;
	assign stage_state[0] = plaintext;
	assign stage_key[0]   = {key_high, key_low};

	// round stages
	for (genvar r = 1; r <= ROUND_COUNT; r++) begin : g_round
		prs80_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.rnd       (RC_W'(r)),
			.in_valid  (stage_valid[r-1]),
			.in_state  (stage_state[r-1]),
			.in_key    (stage_key[r-1]),
			.out_valid (stage_valid[r]),
			.out_state (stage_state[r]),
			.out_key   (stage_key[r])
		);
	end

	// final key addition, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= stage_valid[ROUND_COUNT];
		end
	end

	// final key addition, data
	always_ff @(posedge clk) begin
		ciphertext_q <= stage_state[ROUND_COUNT] ^ round_key(stage_key[ROUND_COUNT]);
	end

	assign done       = done_q;
	assign ciphertext = ciphertext_q;

	// checks
	`ASSERT_CLK(a_never_busy, clk, arst_n, !busy)
	`ASSERT_IMPL(a_req_gives_done, clk, arst_n, start && !busy, ##32 done)
	`ASSERT_IMPL(a_done_has_req, clk, arst_n, done, $past(start, 32))

endmodule
